[hw/rtl/dclg_pkg.sv]
// ----------------------------------------------------------------------------
// dclg_pkg
// shared types and constants of the dimmer channel level generator
// ----------------------------------------------------------------------------
package dclg_pkg;

    localparam int LEVEL_W      = 8;
    localparam int MAX_CHANNELS = 8;
    localparam int PACKED_W     = LEVEL_W * MAX_CHANNELS;
    localparam int ADDR_W       = 9;
    localparam int TOTAL_W      = 10;
    localparam int CHASE_W      = 3;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = TOTAL_W;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TEST_MODE      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_CHANNELS = 1'd1;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 10'd512;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_OFF   = 8'd0;
    localparam logic [ADDR_W-1:0]  ADDR_ANALOG = 9'd0;
    localparam logic [ADDR_W-1:0]  ADDR_CHASE  = 9'd256;

    // per-tick controls shared by all lanes
    typedef struct packed {
        logic                 test_mode;
        logic                 dmx_valid;
        logic [ADDR_W-1:0]    switch_address;
        logic [TOTAL_W-1:0]   total_channels;
    } lane_ctrl_t;

    // fader state seen by the lanes
    typedef struct packed {
        logic [LEVEL_W-1:0]   level;
        logic [CHASE_W-1:0]   chase_index;
    } fader_status_t;

endpackage

[hw/rtl/dclg_if.sv]
// ----------------------------------------------------------------------------
// dclg_in_if / dclg_out_if
// valid/ready channels for refresh ticks and packed channel levels
// ----------------------------------------------------------------------------
interface dclg_in_if;
    import dclg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ADDR_W-1:0]     switch_address;
    logic                  dmx_valid;
    logic [PACKED_W-1:0]   dmx_levels;
    logic [PACKED_W-1:0]   analog_levels;

    modport source (output valid, switch_address, dmx_valid, dmx_levels, analog_levels,
                    input ready);
    modport sink   (input valid, switch_address, dmx_valid, dmx_levels, analog_levels,
                    output ready);
endinterface

interface dclg_out_if;
    import dclg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PACKED_W-1:0]   channel_levels;

    modport source (output valid, channel_levels, input ready);
    modport sink   (input valid, channel_levels, output ready);
endinterface

[hw/rtl/dclg_lane.sv]
// ----------------------------------------------------------------------------
// dclg_lane
// next level of one dimmer channel for one refresh tick
// ----------------------------------------------------------------------------
module dclg_lane #(
    parameter int LANE_INDEX = 0
) (
    input  dclg_pkg::lane_ctrl_t                ctrl,
    input  dclg_pkg::fader_status_t             fader,
    input  logic [dclg_pkg::LEVEL_W-1:0]        dmx_level,
    input  logic [dclg_pkg::LEVEL_W-1:0]        analog_level,
    input  logic [dclg_pkg::LEVEL_W-1:0]        held_level,
    output logic [dclg_pkg::LEVEL_W-1:0]        level_next
);
    import dclg_pkg::*;

    logic [TOTAL_W-1:0] slot;
    logic               slot_in_range;
    logic               addr_bit;
    logic               chase_hit;
    logic [LEVEL_W-1:0] merged;

    assign slot          = TOTAL_W'(ctrl.switch_address) + TOTAL_W'(LANE_INDEX);
    assign slot_in_range = slot < ctrl.total_channels;
    assign addr_bit      = ctrl.switch_address[LANE_INDEX];
    assign chase_hit     = fader.chase_index == CHASE_W'(LANE_INDEX);
    assign merged        = (dmx_level > analog_level) ? dmx_level : analog_level;

    always_comb
    begin
        if (ctrl.test_mode)
        begin
            if (ctrl.switch_address == ADDR_CHASE)
                level_next = chase_hit ? fader.level : LEVEL_OFF;
            else if (ctrl.switch_address > ADDR_CHASE)
                level_next = addr_bit ? fader.level : LEVEL_OFF;
            else if (ctrl.switch_address == ADDR_ANALOG)
                level_next = analog_level;
            else
                level_next = addr_bit ? LEVEL_FULL : LEVEL_OFF;
        end
        else if (ctrl.dmx_valid)
        begin
            level_next = slot_in_range ? merged : held_level;
        end
        else
        begin
            level_next = analog_level;
        end
    end

endmodule

[hw/rtl/dclg_fader.sv]
// ----------------------------------------------------------------------------
// dclg_fader
// triangle fader and chase pointer, stepped once per test-mode tick
// ----------------------------------------------------------------------------
module dclg_fader #(
    parameter int CHANNEL_COUNT = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic [dclg_pkg::ADDR_W-1:0]        switch_address,
    output dclg_pkg::fader_status_t            status
);
    import dclg_pkg::*;

    typedef enum logic [1:0] {
        PH_INC  = 2'd0,
        PH_DEC  = 2'd1,
        PH_NEXT = 2'd2
    } phase_t;

    phase_t             phase_reg, phase_mid, phase_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [CHASE_W-1:0] chase_reg, chase_next, chase_plus;

    assign chase_plus = chase_reg + CHASE_W'(1);

    always_comb
    begin
        // pattern-dependent phase handling comes before the fader step
        phase_mid  = phase_reg;
        chase_next = chase_reg;
        if (switch_address == ADDR_CHASE)
        begin
            if (phase_reg == PH_NEXT)
            begin
                chase_next = ((CHASE_W+1)'(chase_plus) >= (CHASE_W+1)'(CHANNEL_COUNT))
                             ? '0 : chase_plus;
                phase_mid  = PH_INC;
            end
        end
        else if (switch_address > ADDR_CHASE)
        begin
            if (phase_reg == PH_NEXT)
                phase_mid = PH_INC;
        end

        level_next = level_reg;
        phase_next = phase_mid;
        case (phase_mid)
            PH_INC:
            begin
                if (level_reg == LEVEL_FULL)
                begin
                    level_next = LEVEL_FULL - LEVEL_W'(1);
                    phase_next = PH_DEC;
                end
                else
                    level_next = level_reg + LEVEL_W'(1);
            end
            PH_DEC:
            begin
                if (level_reg == LEVEL_OFF)
                    phase_next = PH_NEXT;
                else
                    level_next = level_reg - LEVEL_W'(1);
            end
            PH_NEXT: level_next = LEVEL_OFF;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_INC;
            level_reg <= LEVEL_OFF;
            chase_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            level_reg <= level_next;
            chase_reg <= chase_next;
        end
    end

    assign status.level       = level_reg;
    assign status.chase_index = chase_reg;

endmodule

[hw/rtl/dimmer_channel_level_generator_unit.sv]
// ----------------------------------------------------------------------------
// dimmer_channel_level_generator_unit
// dimmer channel levels from dmx/analog inputs or built-in test patterns
// ----------------------------------------------------------------------------
// Each transfer on tick is one refresh of all channels; the block answers with
// one transfer on levels carrying the packed channel levels, channel 0 in the
// low byte, bytes at and above CHANNEL_COUNT zero. While tick.ready holds, a tick
// is taken every cycle and its result is registered: one lane per channel does a
// single level of compare and select, and the held-level register doubles as
// the output payload register. tick.ready stays high while the output register
// is empty or being emptied in the same cycle. In normal mode the channel takes
// max(dmx, analog) when dmx is valid and its slot is below total_channels,
// otherwise holds; without valid dmx it follows analog. In test mode the
// switch address picks analog pass-through, full-on mask, a fader chase, or
// a masked fader; the fader steps once per test-mode tick. Write configuration
// only while the block is idle.
// ----------------------------------------------------------------------------
module dimmer_channel_level_generator_unit #(
    parameter int CHANNEL_COUNT = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dclg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dclg_pkg::CFG_DATA_W-1:0]      cfg_data,
    dclg_in_if.sink                              tick,
    dclg_out_if.source                           levels
);
    import dclg_pkg::*;

    // bits of the packed word that real channels occupy
    localparam logic [PACKED_W-1:0] LEVEL_MASK =
        (CHANNEL_COUNT >= MAX_CHANNELS) ? {PACKED_W{1'b1}}
                                        : ((PACKED_W'(1) << (LEVEL_W * CHANNEL_COUNT))
                                           - PACKED_W'(1));

    // configuration registers
    logic               test_mode_reg;
    logic [TOTAL_W-1:0] total_channels_reg;

    // handshake
    logic accept;
    logic out_valid_reg, out_valid_next;

    // lanes and merge
    lane_ctrl_t         ctrl;
    fader_status_t      fader;
    logic [LEVEL_W-1:0] held_reg  [CHANNEL_COUNT];
    logic [LEVEL_W-1:0] held_next [CHANNEL_COUNT];
    logic [PACKED_W-1:0] packed_levels;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            test_mode_reg      <= 1'b0;
            total_channels_reg <= TOTAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEST_MODE:      test_mode_reg      <= cfg_data[0];
                REG_TOTAL_CHANNELS: total_channels_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // output register empties or is taken this cycle -> room for a new tick
    assign tick.ready     = !out_valid_reg || levels.ready;
    assign accept         = tick.valid && tick.ready;
    assign out_valid_next = accept || (out_valid_reg && !levels.ready);

    assign ctrl.test_mode      = test_mode_reg;
    assign ctrl.dmx_valid      = tick.dmx_valid;
    assign ctrl.switch_address = tick.switch_address;
    assign ctrl.total_channels = total_channels_reg;

    // fader reads its pre-step value for this tick, steps on the same edge
    dclg_fader #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_fader (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (accept && test_mode_reg),
        .switch_address (tick.switch_address),
        .status         (fader)
    );

    for (genvar i = 0; i < CHANNEL_COUNT; i++)
    begin : g_lane
        dclg_lane #(
            .LANE_INDEX (i)
        ) u_lane (
            .ctrl         (ctrl),
            .fader        (fader),
            .dmx_level    (tick.dmx_levels[LEVEL_W*i +: LEVEL_W]),
            .analog_level (tick.analog_levels[LEVEL_W*i +: LEVEL_W]),
            .held_level   (held_reg[i]),
            .level_next   (held_next[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
                held_reg[i] <= LEVEL_OFF;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                for (int i = 0; i < CHANNEL_COUNT; i++)
                    held_reg[i] <= held_next[i];
            end
        end
    end

    // merge: pack lane levels, unused channels read zero
    always_comb
    begin
        packed_levels = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++)
            packed_levels[LEVEL_W*i +: LEVEL_W] = held_reg[i];
    end

    assign levels.valid          = out_valid_reg;
    assign levels.channel_levels = packed_levels;

    // a result only appears after a tick was taken
    a_valid_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(levels.valid) |-> $past(accept))
        else $error("result valid without an accepted tick");

    // held levels change only on an accepted tick
    a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(levels.channel_levels))
        else $error("channel levels changed without a tick");

    // no back-pressure while the output register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !levels.valid |-> tick.ready)
        else $error("tick stalled with empty output register");

    // missing channels always read zero
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (levels.channel_levels & ~LEVEL_MASK) == '0)
        else $error("unused channel byte is non-zero");

endmodule
